[hdl/upt_pkg.sv]
package upt_pkg;

  localparam int NumUnits = 8;
  localparam int IdW      = 3;
  localparam int CountW   = 4;
  localparam int PctW     = 7;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_t;

  typedef struct packed {
    logic              fire;
    kind_t             kind;
    logic [IdW-1:0]    slot;
    logic [IdW-1:0]    unit_id;
    logic [PctW-1:0]   percent;
    logic              new_unit;
    logic [CountW-1:0] unit_count;
  } upt_result_t;

  // floor(n * 667 / 100) for every 4-bit step
  localparam logic [PctW-1:0] PctTable [16] = '{
    7'd0,  7'd6,  7'd13, 7'd20, 7'd26, 7'd33, 7'd40, 7'd46,
    7'd53, 7'd60, 7'd66, 7'd73, 7'd80, 7'd86, 7'd93, 7'd100
  };

endpackage

[hdl/upt_core.sv]
module upt_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output upt_pkg::upt_result_t res
);

  logic [7:0]                        prev_byte;
  logic [upt_pkg::NumUnits-1:0]      map_valid;
  logic [upt_pkg::IdW-1:0]           map_slot [upt_pkg::NumUnits];
  logic [upt_pkg::CountW-1:0]        slots_used;
  logic [upt_pkg::CountW-1:0]        slots_used_next;

  logic                    dup;
  logic                    clr;
  logic [upt_pkg::IdW-1:0] unit;
  logic                    mapped;
  logic                    full;
  logic                    fresh;
  logic [upt_pkg::IdW-1:0] slot;

  assign dup    = (rx_byte == prev_byte);
  assign clr    = rx_byte[7];
  assign unit   = rx_byte[6:4];
  assign mapped = map_valid[unit];
  assign full   = (slots_used == upt_pkg::CountW'(upt_pkg::NumUnits));
  assign fresh  = !mapped && !full;

  always_comb begin
    if (mapped) begin
      slot = map_slot[unit];
    end else if (full) begin
      slot = '0;
    end else begin
      slot = slots_used[upt_pkg::IdW-1:0];
    end
  end

  assign slots_used_next = clr ? '0 : slots_used + upt_pkg::CountW'(fresh);

  always_comb begin
    res.fire = !dup;
    if (clr) begin
      res.kind       = upt_pkg::KIND_CLEAR;
      res.slot       = '0;
      res.unit_id    = '0;
      res.percent    = '0;
      res.new_unit   = 1'b0;
      res.unit_count = '0;
    end else begin
      res.kind       = upt_pkg::KIND_UPDATE;
      res.slot       = slot;
      res.unit_id    = unit;
      res.percent    = upt_pkg::PctTable[rx_byte[3:0]];
      res.new_unit   = fresh;
      res.unit_count = slots_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte  <= '0;
      map_valid  <= '0;
      slots_used <= '0;
    end else if (take && !dup) begin
      prev_byte  <= rx_byte;
      slots_used <= slots_used_next;
      if (clr) begin
        map_valid <= '0;
      end else if (fresh) begin
        map_valid[unit] <= 1'b1;
      end
    end
  end

  // slot numbers are only read behind their valid bit
  always_ff @(posedge clk) begin
    if (take && !dup && !clr && fresh) begin
      map_slot[unit] <= slot;
    end
  end

endmodule

[hdl/unit_progress_tracker.sv]
// a result is registered and is valid the cycle after its byte transfers
// throughput: one byte per cycle if out_ready is high; the output register frees itself on the same edge it is taken
// a repeated byte transfers but gives no result
// synchronous active-high reset clears the previous byte to 0, unmaps every unit,
// zeroes the slot count and empties the output register
module unit_progress_tracker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [2:0] slot,
  output logic [2:0] unit_id,
  output logic [6:0] percent,
  output logic       new_unit,
  output logic [3:0] unit_count
);

  upt_pkg::upt_result_t res;
  logic                 take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  upt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res.fire;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.fire) begin
      kind       <= res.kind;
      slot       <= res.slot;
      unit_id    <= res.unit_id;
      percent    <= res.percent;
      new_unit   <= res.new_unit;
      unit_count <= res.unit_count;
    end
  end

endmodule

[hdl/upt_checker.sv]
module upt_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [2:0] slot,
  input logic [2:0] unit_id,
  input logic [6:0] percent,
  input logic       new_unit,
  input logic [3:0] unit_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot)
      && $stable(unit_id) && $stable(percent) && $stable(new_unit) && $stable(unit_count))
    else $error("result changed while stalled");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> slot == 3'd0 && unit_id == 3'd0 && percent == 7'd0
      && !new_unit && unit_count == 4'd0)
    else $error("clear result carries nonzero fields");

  a_update_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> unit_count != 4'd0 && unit_count <= 4'd8 && percent <= 7'd100)
    else $error("update result out of range");

  // a fresh unit takes the next slot in order
  a_fresh_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind && new_unit |-> unit_count == ({1'b0, slot} + 4'd1))
    else $error("fresh slot does not match slot count");

endmodule

bind unit_progress_tracker upt_checker u_upt_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .slot       (slot),
  .unit_id    (unit_id),
  .percent    (percent),
  .new_unit   (new_unit),
  .unit_count (unit_count)
);

[tb/unit_progress_tracker_tb.sv]
module unit_progress_tracker_tb;

  localparam int CycleLimit = 200000;
  localparam int StallCycles = 80;

  class progress_scoreboard;
    logic [7:0] last_byte;
    bit unit_mapped[upt_pkg::NumUnits];
    logic [upt_pkg::IdW-1:0] unit_slot[upt_pkg::NumUnits];
    logic [upt_pkg::CountW-1:0] used;
    upt_pkg::upt_result_t pending_q[$];
    int results_queued;
    int mismatches;

    function new();
      last_byte = 8'h00;
      results_queued = 0;
      mismatches = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < upt_pkg::NumUnits; i++) begin
        unit_mapped[i] = 1'b0;
        unit_slot[i] = '0;
      end
      used = '0;
    endfunction

    function void note_byte(logic [7:0] b);
      upt_pkg::upt_result_t r;
      logic [upt_pkg::IdW-1:0] u;
      int p;
      if (b == last_byte) return;
      last_byte = b;
      r = '0;
      r.fire = 1'b1;
      if (b[7]) begin
        clear_table();
        r.kind = upt_pkg::KIND_CLEAR;
      end else begin
        u = b[6:4];
        r.kind = upt_pkg::KIND_UPDATE;
        r.unit_id = u;
        if (unit_mapped[u]) begin
          r.slot = unit_slot[u];
        end else if (used < upt_pkg::NumUnits) begin
          r.slot = used[upt_pkg::IdW-1:0];
          unit_mapped[u] = 1'b1;
          unit_slot[u] = r.slot;
          used = used + 1'b1;
          r.new_unit = 1'b1;
        end else begin
          r.slot = '0;
        end
        p = (int'(b[3:0]) * 667) / 100;
        if (p > 100) p = 100;
        r.percent = p[upt_pkg::PctW-1:0];
        r.unit_count = used;
      end
      pending_q.push_back(r);
      results_queued++;
    endfunction

    function void check_result(upt_pkg::upt_result_t got);
      upt_pkg::upt_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d slot=%0d unit=%0d pct=%0d new=%0d count=%0d",
                   got.kind, got.slot, got.unit_id, got.percent, got.new_unit,
                   got.unit_count);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind || got.slot !== want.slot || got.unit_id !== want.unit_id ||
          got.percent !== want.percent || got.new_unit !== want.new_unit ||
          got.unit_count !== want.unit_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected kind=%0d slot=%0d unit=%0d pct=%0d new=%0d count=%0d",
                   want.kind, want.slot, want.unit_id, want.percent, want.new_unit,
                   want.unit_count);
          $display("          got      kind=%0d slot=%0d unit=%0d pct=%0d new=%0d count=%0d",
                   got.kind, got.slot, got.unit_id, got.percent, got.new_unit,
                   got.unit_count);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [2:0] slot;
  logic [2:0] unit_id;
  logic [6:0] percent;
  logic new_unit;
  logic [3:0] unit_count;

  progress_scoreboard tracker;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_request = 1'b0;

  unit_progress_tracker dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .slot(slot),
    .unit_id(unit_id),
    .percent(percent),
    .new_unit(new_unit),
    .unit_count(unit_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    for (int cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // result side: check each transfer, then pick out_ready for the next edge
  initial begin
    upt_pkg::upt_result_t got;
    int hold;
    hold = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '0;
        got.fire = 1'b1;
        got.kind = upt_pkg::kind_t'(kind);
        got.slot = slot;
        got.unit_id = unit_id;
        got.percent = percent;
        got.new_unit = new_unit;
        got.unit_count = unit_count;
        tracker.check_result(got);
      end
      if (stall_request) begin
        stall_request = 1'b0;
        hold = StallCycles;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b);
  endtask

  // mostly unit updates, some clears, some repeats of the last byte
  task automatic run_phase(input int send_pct, input int recv_pct, input int results);
    int target;
    int roll;
    logic [7:0] b;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = tracker.results_queued + results;
    while (tracker.results_queued < target) begin
      roll = $urandom_range(99);
      if (roll < 5)
        b = {1'b1, 7'($urandom_range(127))};
      else if (roll < 14)
        b = tracker.last_byte;
      else if (roll < 17)
        b = 8'($urandom_range(255));
      else
        b = {1'b0, 3'($urandom_range(7)), 4'($urandom_range(15))};
      send_byte(b);
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    tracker = new();
    directed = '{8'h00, 8'h00, 8'h05, 8'h15, 8'h1F, 8'h1F, 8'h20, 8'h3A, 8'h4F, 8'h50,
                 8'h61, 8'h7F, 8'h0F, 8'h80, 8'h80, 8'h7E, 8'hFF, 8'hFF, 8'h00, 8'h10,
                 8'hA5, 8'h6C, 8'h6C, 8'h23};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_byte(directed[i]);
    run_phase(18, 45, 520);
    run_phase(45, 18, 520);
    run_phase(0, 0, 250);
    stall_request = 1'b1;
    run_phase(0, 0, 260);
    in_valid <= 1'b0;
    while (tracker.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
hdl/upt_pkg.sv
hdl/upt_core.sv
hdl/unit_progress_tracker.sv
hdl/upt_checker.sv
tb/unit_progress_tracker_tb.sv
